/* hdl/acbd_pkg.sv */
// Package: shared constants, codes and types of the animation channel bit decoder.
package acbd_pkg;

	localparam int WINDOW_BITS = 64;
	localparam int BUF_W       = $clog2(WINDOW_BITS + 1);
	localparam int PUSH_BITS   = 32;
	localparam int DESC_W      = 16;
	localparam int FIELD_W     = 15;
	localparam int FRAC_W      = 14;
	localparam int JOINT_W     = 8;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 16;

	localparam logic [DESC_W-1:0] ROT_BASE_MASK   = 16'hfff0;
	localparam logic [DESC_W-1:0] SCALE_BASE_MASK = 16'hffc0;
	localparam logic [DESC_W-1:0] TRANS_BASE_MASK = 16'hfff0;

	// descriptor bit positions
	localparam int DESC_MORE_BIT  = 4;
	localparam int DESC_TRANS_BIT = 5;

	typedef enum logic {
		FUNC_DESC = 1'b0,
		FUNC_PUSH = 1'b1
	} func_t;

	typedef enum logic {
		STATUS_OK      = 1'b0,
		STATUS_STARVED = 1'b1
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAC   = 2'd0,
		CFG_JOINTS = 2'd1
	} cfg_idx_t;

	typedef enum logic {
		PHASE_ROT   = 1'b0,
		PHASE_EXTRA = 1'b1
	} phase_t;

	typedef enum logic [1:0] {
		KIND_ROT   = 2'd0,
		KIND_SCALE = 2'd1,
		KIND_TRANS = 2'd2
	} kind_t;

	// field take request from the control logic to the interpolator
	typedef struct packed {
		kind_t      kind;
		logic [3:0] width;
	} take_req_t;

endpackage

/* hdl/acbd_if.sv */
// Interfaces: input word, output record and configuration write channels.
interface acbd_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [15:0] descriptor;
	logic [31:0] stream_word_a;
	logic [31:0] stream_word_b;

	modport source (output valid, func, descriptor, stream_word_a, stream_word_b, input ready);
	modport sink (input valid, func, descriptor, stream_word_a, stream_word_b, output ready);
endinterface

interface acbd_out_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [7:0]  joint_index;
	logic [1:0]  axis;
	logic [15:0] rotation;
	logic [15:0] scale;
	logic [15:0] translation;
	logic        last;

	modport source (output valid, status, joint_index, axis, rotation, scale, translation,
		last, input ready);
	modport sink (input valid, status, joint_index, axis, rotation, scale, translation,
		last, output ready);
endinterface

interface acbd_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [15:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* hdl/anim_channel_bit_decoder.sv */
// Top level: animation channel bit decoder with input register and record register.
//
//  channel   role    word
//  items     sink    func, descriptor, stream_word_a, stream_word_b
//  records   source  status, joint_index, axis, rotation, scale, translation, last
//  cfg       sink    index, data (0 subframe_fraction, 1 joint_count)
//
// One word per cycle sustained unless the record register is held.
// The decode cycle is one barrel extraction, a 17x14 multiply and the base add.
// A word moves into decode only when the record register is empty or being taken.
// Reset clears the bit windows' fill count, the channel position and both registers.
module anim_channel_bit_decoder (
	input  logic clk,
	input  logic arst_n,
	acbd_in_if.sink     items,
	acbd_out_if.source  records,
	acbd_cfg_if.sink    cfg
);

	// configuration
	logic [acbd_pkg::FRAC_W-1:0]  frac_q;
	logic [acbd_pkg::JOINT_W-1:0] joints_q;

	// input stage
	logic                         valid_s1;
	logic                         func_s1;
	logic [acbd_pkg::DESC_W-1:0]  desc_s1;
	logic [31:0]                  word_a_s1;
	logic [31:0]                  word_b_s1;

	// decode state
	logic [acbd_pkg::WINDOW_BITS-1:0] win_a_q;
	logic [acbd_pkg::WINDOW_BITS-1:0] win_b_q;
	logic [acbd_pkg::BUF_W-1:0]       bits_q;
	acbd_pkg::phase_t                 phase_q;
	logic                             more_trans_q;
	logic [15:0]                      pend_rot_q;
	logic [15:0]                      pend_scale_q;
	logic [1:0]                       axis_q;
	logic [acbd_pkg::JOINT_W-1:0]     joint_q;

	// record register
	logic        rec_valid_q;
	logic        rec_status_q;
	logic [7:0]  rec_joint_q;
	logic [1:0]  rec_axis_q;
	logic [15:0] rec_rot_q;
	logic [15:0] rec_scale_q;
	logic [15:0] rec_trans_q;
	logic        rec_last_q;

	logic                       out_free;
	logic                       adv;
	acbd_pkg::take_req_t        req;
	logic [acbd_pkg::BUF_W-1:0] remain;
	logic [15:0]                contrib;
	logic                       is_desc;
	logic                       is_push;
	logic                       push_fits;
	logic                       starved;
	logic                       decode;
	logic [15:0]                base;
	logic [15:0]                value;
	logic                       emit;
	logic [15:0]                e_rot;
	logic [15:0]                e_scale;
	logic [15:0]                e_trans;
	logic                       last;

	assign out_free    = !rec_valid_q || records.ready;
	assign adv         = valid_s1 && out_free;
	assign items.ready = !valid_s1 || out_free;
	assign cfg.ready   = 1'b1;

	assign records.valid       = rec_valid_q;
	assign records.status      = rec_status_q;
	assign records.joint_index = rec_joint_q;
	assign records.axis        = rec_axis_q;
	assign records.rotation    = rec_rot_q;
	assign records.scale       = rec_scale_q;
	assign records.translation = rec_trans_q;
	assign records.last        = rec_last_q;

	always_comb begin
		req.width = desc_s1[3:0];
		priority if (phase_q == acbd_pkg::PHASE_ROT) begin
			req.kind = acbd_pkg::KIND_ROT;
		end else if (!more_trans_q && desc_s1[acbd_pkg::DESC_MORE_BIT]) begin
			req.kind = acbd_pkg::KIND_SCALE;
		end else begin
			req.kind = acbd_pkg::KIND_TRANS;
		end
	end

	acbd_interp u_interp (
		.window_a (win_a_q),
		.window_b (win_b_q),
		.bits     (bits_q),
		.frac     (frac_q),
		.req      (req),
		.remain   (remain),
		.contrib  (contrib)
	);

	always_comb begin
		is_push   = func_s1 == acbd_pkg::FUNC_PUSH;
		is_desc   = !is_push && (joints_q != '0);
		push_fits = ({1'b0, bits_q} + (acbd_pkg::BUF_W + 1)'(acbd_pkg::PUSH_BITS))
			<= (acbd_pkg::BUF_W + 1)'(acbd_pkg::WINDOW_BITS);
		starved   = acbd_pkg::BUF_W'(req.width) > bits_q;
		decode    = is_desc && !starved;

		unique case (req.kind)
			acbd_pkg::KIND_ROT:   base = desc_s1 & acbd_pkg::ROT_BASE_MASK;
			acbd_pkg::KIND_SCALE: base = desc_s1 & acbd_pkg::SCALE_BASE_MASK;
			default:              base = desc_s1 & acbd_pkg::TRANS_BASE_MASK;
		endcase
		value = base + contrib;

		emit    = 1'b0;
		e_rot   = pend_rot_q;
		e_scale = pend_scale_q;
		e_trans = '0;
		unique case (req.kind)
			acbd_pkg::KIND_ROT: begin
				emit    = !desc_s1[acbd_pkg::DESC_MORE_BIT];
				e_rot   = value;
				e_scale = '0;
			end
			acbd_pkg::KIND_SCALE: begin
				emit    = !desc_s1[acbd_pkg::DESC_TRANS_BIT];
				e_scale = value;
			end
			default: begin
				emit    = 1'b1;
				e_trans = value;
			end
		endcase
		emit = emit && decode;
		// a lowered joint count in mid-channel also ends the channel
		last = (axis_q == 2'd2) && (({1'b0, joint_q} + 9'd1) >= {1'b0, joints_q});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frac_q   <= '0;
			joints_q <= '0;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				acbd_pkg::CFG_FRAC:   frac_q   <= cfg.data[acbd_pkg::FRAC_W-1:0];
				acbd_pkg::CFG_JOINTS: joints_q <= cfg.data[acbd_pkg::JOINT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (items.ready) begin
			valid_s1 <= items.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (items.ready && items.valid) begin
			func_s1   <= items.func;
			desc_s1   <= items.descriptor;
			word_a_s1 <= items.stream_word_a;
			word_b_s1 <= items.stream_word_b;
		end
	end

	// bit windows hold payload only; the fill count guards them
	always_ff @(posedge clk) begin
		if (adv && is_push && push_fits) begin
			win_a_q <= {win_a_q[acbd_pkg::WINDOW_BITS-acbd_pkg::PUSH_BITS-1:0], word_a_s1};
			win_b_q <= {win_b_q[acbd_pkg::WINDOW_BITS-acbd_pkg::PUSH_BITS-1:0], word_b_s1};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q       <= '0;
			phase_q      <= acbd_pkg::PHASE_ROT;
			more_trans_q <= 1'b0;
			pend_rot_q   <= '0;
			pend_scale_q <= '0;
			axis_q       <= '0;
			joint_q      <= '0;
		end else if (adv) begin
			if (is_push) begin
				if (push_fits) begin
					bits_q <= bits_q + acbd_pkg::BUF_W'(acbd_pkg::PUSH_BITS);
				end
			end else if (decode) begin
				// channel end drops the leftover stream bits
				bits_q <= (emit && last) ? '0 : remain;
				if (emit) begin
					phase_q      <= acbd_pkg::PHASE_ROT;
					more_trans_q <= 1'b0;
					pend_rot_q   <= '0;
					pend_scale_q <= '0;
					if (last) begin
						axis_q  <= '0;
						joint_q <= '0;
					end else if (axis_q == 2'd2) begin
						axis_q  <= '0;
						joint_q <= joint_q + 1'b1;
					end else begin
						axis_q <= axis_q + 1'b1;
					end
				end else if (req.kind == acbd_pkg::KIND_ROT) begin
					pend_rot_q   <= value;
					pend_scale_q <= '0;
					more_trans_q <= 1'b0;
					phase_q      <= acbd_pkg::PHASE_EXTRA;
				end else begin
					pend_scale_q <= value;
					more_trans_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q <= 1'b0;
		end else if (out_free) begin
			rec_valid_q <= valid_s1 && is_desc && (starved || emit);
		end
	end

	always_ff @(posedge clk) begin
		if (out_free) begin
			rec_joint_q <= joint_q;
			rec_axis_q  <= axis_q;
			if (starved) begin
				rec_status_q <= acbd_pkg::STATUS_STARVED;
				rec_rot_q    <= '0;
				rec_scale_q  <= '0;
				rec_trans_q  <= '0;
				rec_last_q   <= 1'b0;
			end else begin
				rec_status_q <= acbd_pkg::STATUS_OK;
				rec_rot_q    <= e_rot;
				rec_scale_q  <= e_scale;
				rec_trans_q  <= e_trans;
				rec_last_q   <= last;
			end
		end
	end

endmodule

/* hdl/acbd_interp.sv */
// Field extraction from both bit windows and keyframe interpolation.
module acbd_interp (
	input  logic [acbd_pkg::WINDOW_BITS-1:0] window_a,
	input  logic [acbd_pkg::WINDOW_BITS-1:0] window_b,
	input  logic [acbd_pkg::BUF_W-1:0]       bits,
	input  logic [acbd_pkg::FRAC_W-1:0]      frac,
	input  acbd_pkg::take_req_t              req,
	output logic [acbd_pkg::BUF_W-1:0]       remain,
	output logic [15:0]                      contrib
);

	logic [acbd_pkg::WINDOW_BITS-1:0] ext_a;
	logic [acbd_pkg::WINDOW_BITS-1:0] ext_b;
	logic [acbd_pkg::FIELD_W-1:0]     mask;
	logic [acbd_pkg::FIELD_W-1:0]     va;
	logic [acbd_pkg::FIELD_W-1:0]     vb;
	logic signed [16:0]               diff;
	logic signed [16:0]               dsel;
	logic signed [31:0]               prod;
	logic [15:0]                      step;
	logic [15:0]                      v;

	always_comb begin
		remain = bits - acbd_pkg::BUF_W'(req.width);
		ext_a  = window_a >> remain;
		ext_b  = window_b >> remain;
		mask   = acbd_pkg::FIELD_W'((16'd1 << req.width) - 16'd1);
		va     = ext_a[acbd_pkg::FIELD_W-1:0] & mask;
		vb     = ext_b[acbd_pkg::FIELD_W-1:0] & mask;
		diff   = $signed({2'b00, vb}) - $signed({2'b00, va});
		unique case (req.kind)
			acbd_pkg::KIND_ROT:   dsel = {{3{diff[13]}}, diff[13:0]};
			acbd_pkg::KIND_TRANS: dsel = {diff[15], diff[15:0]};
			default:              dsel = diff;
		endcase
		prod = dsel * $signed({17'd0, frac});
		// arithmetic shift gives the floor of the scaled difference
		step = 16'(prod >>> acbd_pkg::FRAC_W);
		v    = {1'b0, va} + step;
		unique case (req.kind)
			acbd_pkg::KIND_ROT:   contrib = {v[13:0], 2'b00};
			acbd_pkg::KIND_SCALE: contrib = {v[14:0], 1'b0};
			default:              contrib = v;
		endcase
	end

endmodule

/* tb/tb_anim_channel_bit_decoder.sv */
// Testbench for the animation channel bit decoder: directed and random words, record checks.
module tb_anim_channel_bit_decoder;

	localparam int STALL_LIMIT = 3000;
	localparam int DRAIN_PAUSE = 10;
	localparam int TAIL_CYCLES = 20;
	localparam int HOLD_CYCLES = 250;
	localparam int HOLD_AFTER  = 150;
	localparam int PHASE_WORDS = 300;

	typedef struct packed {
		acbd_pkg::func_t func;
		logic [15:0]     desc;
		logic [31:0]     word_a;
		logic [31:0]     word_b;
	} word_t;

	typedef struct packed {
		acbd_pkg::status_t status;
		logic [7:0]        joint;
		logic [1:0]        axis;
		logic [15:0]       rot;
		logic [15:0]       scl;
		logic [15:0]       trn;
		logic              last;
	} rec_t;

	typedef struct {
		logic [acbd_pkg::WINDOW_BITS-1:0] win_a;
		logic [acbd_pkg::WINDOW_BITS-1:0] win_b;
		int unsigned                      fill;
		acbd_pkg::phase_t                 phase;
		logic                             more_trn;
		logic [15:0]                      pend_rot;
		logic [15:0]                      pend_scl;
		int unsigned                      axis_cnt;
		int unsigned                      joint_cnt;
		logic [acbd_pkg::FRAC_W-1:0]      frac;
		logic [acbd_pkg::JOINT_W-1:0]     joints;
	} dec_state_t;

	logic clk = 1'b0;
	logic arst_n;

	acbd_in_if  items_if ();
	acbd_out_if records_if ();
	acbd_cfg_if cfg_if ();

	anim_channel_bit_decoder u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items_if),
		.records (records_if),
		.cfg     (cfg_if)
	);

	// decoder state seen by accepted words, and a copy used to plan stimulus
	dec_state_t dec_st;
	dec_state_t plan_st;

	word_t words_to_send[$];
	rec_t  records_due[$];

	bit word_held;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_left;
	bit hold_done;
	int errors;
	int idle_cycles;
	int words_taken;
	int words_planned;
	int records_seen;
	int starved_seen;
	int settings_used;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void dec_reset(output dec_state_t st);
		st.win_a     = '0;
		st.win_b     = '0;
		st.fill      = 0;
		st.phase     = acbd_pkg::PHASE_ROT;
		st.more_trn  = 1'b0;
		st.pend_rot  = '0;
		st.pend_scl  = '0;
		st.axis_cnt  = 0;
		st.joint_cnt = 0;
		st.frac      = '0;
		st.joints    = '0;
	endfunction

	// va + floor((vb - va) * frac / 2^14), difference optionally sign-folded to span bits
	function automatic int lerp(int va, int vb, int span, logic [acbd_pkg::FRAC_W-1:0] frac);
		longint diff;
		longint f;
		longint prod;
		logic signed [13:0] d14;
		logic signed [15:0] d16;
		diff = vb - va;
		d14 = diff[13:0];
		d16 = diff[15:0];
		if (span == 14)
			diff = d14;
		else if (span == 16)
			diff = d16;
		f = frac;
		prod = (diff * f) >>> acbd_pkg::FRAC_W;
		return va + int'(prod);
	endfunction

	function automatic void take_bits(inout dec_state_t st, input int n,
		output int va, output int vb);
		logic [acbd_pkg::WINDOW_BITS-1:0] sa;
		logic [acbd_pkg::WINDOW_BITS-1:0] sb;
		int m;
		m = (1 << n) - 1;
		sa = st.win_a >> (st.fill - n);
		sb = st.win_b >> (st.fill - n);
		va = int'(sa[15:0]) & m;
		vb = int'(sb[15:0]) & m;
		st.fill = st.fill - n;
	endfunction

	function automatic void close_record(inout dec_state_t st, input logic [15:0] rot,
		input logic [15:0] scl, input logic [15:0] trn, output rec_t r);
		logic last;
		last = (st.axis_cnt >= 2) && (st.joint_cnt + 1 >= st.joints);
		r.status = acbd_pkg::STATUS_OK;
		r.joint  = st.joint_cnt[7:0];
		r.axis   = st.axis_cnt[1:0];
		r.rot    = rot;
		r.scl    = scl;
		r.trn    = trn;
		r.last   = last;
		st.phase    = acbd_pkg::PHASE_ROT;
		st.more_trn = 1'b0;
		st.pend_rot = '0;
		st.pend_scl = '0;
		if (last) begin
			st.axis_cnt  = 0;
			st.joint_cnt = 0;
			st.fill      = 0;
		end else if (st.axis_cnt >= 2) begin
			st.axis_cnt  = 0;
			st.joint_cnt = (st.joint_cnt + 1) & 255;
		end else begin
			st.axis_cnt++;
		end
	endfunction

	function automatic void decode_step(inout dec_state_t st, input word_t w,
		output rec_t r, output bit has);
		int n;
		int va;
		int vb;
		logic [15:0] val;
		has = 1'b0;
		r = '0;
		n = w.desc[3:0];
		if (w.func == acbd_pkg::FUNC_PUSH) begin
			if (st.fill + acbd_pkg::PUSH_BITS <= acbd_pkg::WINDOW_BITS) begin
				st.win_a = {st.win_a[acbd_pkg::WINDOW_BITS-acbd_pkg::PUSH_BITS-1:0],
					w.word_a};
				st.win_b = {st.win_b[acbd_pkg::WINDOW_BITS-acbd_pkg::PUSH_BITS-1:0],
					w.word_b};
				st.fill += acbd_pkg::PUSH_BITS;
			end
			return;
		end
		if (st.joints == 0)
			return;
		if (n > st.fill) begin
			has = 1'b1;
			r.status = acbd_pkg::STATUS_STARVED;
			r.joint  = st.joint_cnt[7:0];
			r.axis   = st.axis_cnt[1:0];
			return;
		end
		if (st.phase == acbd_pkg::PHASE_ROT) begin
			val = w.desc & acbd_pkg::ROT_BASE_MASK;
			if (n != 0) begin
				take_bits(st, n, va, vb);
				val = val + 16'(lerp(va, vb, 14, st.frac) << 2);
			end
			if (!w.desc[acbd_pkg::DESC_MORE_BIT]) begin
				close_record(st, val, '0, '0, r);
				has = 1'b1;
				return;
			end
			st.pend_rot = val;
			st.pend_scl = '0;
			st.more_trn = 1'b0;
			st.phase    = acbd_pkg::PHASE_EXTRA;
			return;
		end
		if (!st.more_trn && w.desc[acbd_pkg::DESC_MORE_BIT]) begin
			val = w.desc & acbd_pkg::SCALE_BASE_MASK;
			if (n != 0) begin
				take_bits(st, n, va, vb);
				val = val + 16'(lerp(va, vb, 0, st.frac) << 1);
			end
			if (!w.desc[acbd_pkg::DESC_TRANS_BIT]) begin
				close_record(st, st.pend_rot, val, '0, r);
				has = 1'b1;
				return;
			end
			st.pend_scl = val;
			st.more_trn = 1'b1;
			return;
		end
		val = w.desc & acbd_pkg::TRANS_BASE_MASK;
		if (n != 0) begin
			take_bits(st, n, va, vb);
			val = val + 16'(lerp(va, vb, 16, st.frac));
		end
		close_record(st, st.pend_rot, st.pend_scl, val, r);
		has = 1'b1;
	endfunction

	function automatic string fmt_rec(rec_t r);
		return $sformatf("st=%0d joint=%0d axis=%0d rot=%h scl=%h trn=%h last=%0d",
			r.status, r.joint, r.axis, r.rot, r.scl, r.trn, r.last);
	endfunction

	function automatic word_t mk_desc(logic [15:0] d);
		word_t w;
		w.func   = acbd_pkg::FUNC_DESC;
		w.desc   = d;
		w.word_a = $urandom;
		w.word_b = $urandom;
		return w;
	endfunction

	function automatic word_t mk_push(logic [31:0] a, logic [31:0] b);
		word_t w;
		w.func   = acbd_pkg::FUNC_PUSH;
		w.desc   = 16'($urandom);
		w.word_a = a;
		w.word_b = b;
		return w;
	endfunction

	function automatic logic [3:0] rand_width();
		int r;
		r = $urandom_range(0, 9);
		if (r == 0)
			return 4'd0;
		if (r == 1)
			return 4'd15;
		return 4'($urandom_range(0, 15));
	endfunction

	// queue a word and advance the planning copy; ignored words are not counted
	task automatic add_word(word_t w);
		rec_t r;
		bit has;
		if (w.func == acbd_pkg::FUNC_DESC ? plan_st.joints != 0
			: plan_st.fill + acbd_pkg::PUSH_BITS <= acbd_pkg::WINDOW_BITS)
			words_planned++;
		decode_step(plan_st, w, r, has);
		words_to_send.push_back(w);
	endtask

	task automatic add_field(logic [15:0] d);
		if ($urandom_range(0, 9) < 3)
			add_word(mk_push($urandom, $urandom));
		if (plan_st.fill < d[3:0]) begin
			// now and then send it early so it comes back starved
			if ($urandom_range(0, 9) == 0)
				add_word(mk_desc(d));
			add_word(mk_push($urandom, $urandom));
		end
		add_word(mk_desc(d));
	endtask

	// one axis: rotation, optionally scale and/or translation
	task automatic add_record();
		int kind;
		logic [15:0] d;
		kind = $urandom_range(0, 3);
		d = 16'($urandom);
		d[3:0] = rand_width();
		d[acbd_pkg::DESC_MORE_BIT] = (kind != 0);
		add_field(d);
		if (kind == 1 || kind == 2) begin
			d = 16'($urandom);
			d[3:0] = rand_width();
			d[acbd_pkg::DESC_MORE_BIT] = 1'b1;
			d[acbd_pkg::DESC_TRANS_BIT] = (kind == 2);
			add_field(d);
		end
		if (kind >= 2) begin
			d = 16'($urandom);
			d[3:0] = rand_width();
			d[acbd_pkg::DESC_MORE_BIT] = 1'b0;
			add_field(d);
		end
	endtask

	task automatic cfg_write(acbd_pkg::cfg_idx_t idx, int unsigned val);
		logic [acbd_pkg::CFG_DATA_W-1:0] data;
		data = acbd_pkg::CFG_DATA_W'($urandom);
		if (idx == acbd_pkg::CFG_FRAC)
			data[acbd_pkg::FRAC_W-1:0] = val[acbd_pkg::FRAC_W-1:0];
		else
			data[acbd_pkg::JOINT_W-1:0] = val[acbd_pkg::JOINT_W-1:0];
		@(negedge clk);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= data;
		@(posedge clk);
		while (!cfg_if.ready)
			@(posedge clk);
		if (idx == acbd_pkg::CFG_FRAC)
			dec_st.frac = data[acbd_pkg::FRAC_W-1:0];
		else
			dec_st.joints = data[acbd_pkg::JOINT_W-1:0];
		settings_used++;
		@(negedge clk);
		cfg_if.valid <= 1'b0;
	endtask

	// wait out every queued word and record, then let the pipeline settle
	task automatic drain();
		while (words_to_send.size() != 0 || word_held || records_due.size() != 0)
			@(negedge clk);
		repeat (DRAIN_PAUSE) @(negedge clk);
		plan_st = dec_st;
	endtask

	// driver
	always @(negedge clk) begin
		word_t nxt_word;
		if (arst_n && !word_held) begin
			if (words_to_send.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
				nxt_word = words_to_send.pop_front();
				items_if.func          <= nxt_word.func;
				items_if.descriptor    <= nxt_word.desc;
				items_if.stream_word_a <= nxt_word.word_a;
				items_if.stream_word_b <= nxt_word.word_b;
				items_if.valid         <= 1'b1;
				word_held = 1'b1;
			end else begin
				items_if.valid <= 1'b0;
			end
		end
	end

	// record receiver, with one long hold-off so the input side backs up
	always @(negedge clk) begin
		if (arst_n) begin
			if (!hold_done && records_seen >= HOLD_AFTER) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				records_if.ready <= 1'b0;
			end else begin
				records_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
			end
		end
	end

	// monitor: predict on each taken word, check each record, watch for a hang
	always @(posedge clk) begin
		word_t w;
		rec_t r;
		rec_t got;
		rec_t want;
		bit has;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (items_if.valid && items_if.ready) begin
				w.func   = acbd_pkg::func_t'(items_if.func);
				w.desc   = items_if.descriptor;
				w.word_a = items_if.stream_word_a;
				w.word_b = items_if.stream_word_b;
				decode_step(dec_st, w, r, has);
				if (has)
					records_due.push_back(r);
				words_taken++;
				word_held = 1'b0;
				moved = 1'b1;
			end
			if (records_if.valid && records_if.ready) begin
				got.status = acbd_pkg::status_t'(records_if.status);
				got.joint  = records_if.joint_index;
				got.axis   = records_if.axis;
				got.rot    = records_if.rotation;
				got.scl    = records_if.scale;
				got.trn    = records_if.translation;
				got.last   = records_if.last;
				records_seen++;
				moved = 1'b1;
				if (records_due.size() == 0) begin
					errors++;
					if (errors <= 10)
						$display("unexpected record: %s", fmt_rec(got));
				end else begin
					want = records_due.pop_front();
					if (got.status == acbd_pkg::STATUS_STARVED)
						starved_seen++;
					if (got.status !== want.status || got.joint !== want.joint
						|| got.axis !== want.axis || got.rot !== want.rot
						|| got.scl !== want.scl || got.trn !== want.trn
						|| got.last !== want.last) begin
						errors++;
						if (errors <= 10)
							$display("record %0d mismatch\n  expected %s\n  actual   %s",
								records_seen, fmt_rec(want), fmt_rec(got));
					end
				end
			end
			if (cfg_if.valid && cfg_if.ready)
				moved = 1'b1;
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("no handshake for %0d cycles, %0d records outstanding",
					STALL_LIMIT, records_due.size());
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		items_if.valid         = 1'b0;
		items_if.func          = acbd_pkg::FUNC_DESC;
		items_if.descriptor    = '0;
		items_if.stream_word_a = '0;
		items_if.stream_word_b = '0;
		records_if.ready       = 1'b0;
		cfg_if.valid           = 1'b0;
		cfg_if.index           = acbd_pkg::CFG_FRAC;
		cfg_if.data            = '0;
		dec_reset(dec_st);
		plan_st = dec_st;
		send_idle_pct = 28;
		recv_idle_pct = 72;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// no joints: descriptors are dropped, a push still loads the window
		cfg_write(acbd_pkg::CFG_FRAC, 0);
		cfg_write(acbd_pkg::CFG_JOINTS, 0);
		plan_st = dec_st;
		add_word(mk_desc(16'hffff));
		add_word(mk_push(32'hffff_ffff, 32'h0000_0000));
		drain();

		cfg_write(acbd_pkg::CFG_FRAC, 16383);
		cfg_write(acbd_pkg::CFG_JOINTS, 1);
		plan_st = dec_st;
		add_word(mk_desc(16'h000f));            // full-width rotation, extreme stream bits
		add_word(mk_push($urandom, $urandom));
		add_word(mk_push($urandom, $urandom));  // no room left in the window, dropped
		add_word(mk_push($urandom, $urandom));  // still no room, dropped
		add_word(mk_desc(16'hfff0));            // zero-width rotation, extras follow
		add_word(mk_desc(16'hff3f));            // scale with translation to come
		add_word(mk_desc(16'h800f));            // translation closes the axis
		add_word(mk_desc(16'h123f));            // full-width rotation, extras follow
		add_word(mk_push(32'h0000_0000, 32'hffff_ffff));
		add_word(mk_desc(16'h0015));
		add_word(mk_desc(16'hffef));            // rotation alone, closes the channel
		add_word(mk_desc(16'h0001));            // starved, the window was emptied at channel end
		add_word(mk_push($urandom, $urandom));
		add_word(mk_desc(16'h0013));
		add_word(mk_desc(16'h0fd7));            // scale with no translation
		drain();

		// lower the joint count once the counter has passed it
		cfg_write(acbd_pkg::CFG_FRAC, 0);
		cfg_write(acbd_pkg::CFG_JOINTS, 3);
		plan_st = dec_st;
		repeat (4) add_record();
		drain();
		cfg_write(acbd_pkg::CFG_JOINTS, 1);
		plan_st = dec_st;
		add_record();
		drain();

		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: begin
					cfg_write(acbd_pkg::CFG_FRAC, $urandom_range(0, 16383));
					cfg_write(acbd_pkg::CFG_JOINTS, 2);
				end
				1: begin
					cfg_write(acbd_pkg::CFG_FRAC, 16383);
					cfg_write(acbd_pkg::CFG_JOINTS, $urandom_range(1, 8));
				end
				2: begin
					cfg_write(acbd_pkg::CFG_FRAC, 0);
					cfg_write(acbd_pkg::CFG_JOINTS, 255);
				end
				3: begin
					cfg_write(acbd_pkg::CFG_FRAC, $urandom_range(0, 16383));
					cfg_write(acbd_pkg::CFG_JOINTS, 1);
				end
				4: begin
					cfg_write(acbd_pkg::CFG_FRAC, $urandom_range(0, 16383));
					cfg_write(acbd_pkg::CFG_JOINTS, $urandom_range(1, 20));
				end
				default: begin
					cfg_write(acbd_pkg::CFG_FRAC, 8192);
					cfg_write(acbd_pkg::CFG_JOINTS, 3);
				end
			endcase
			case (ph / 2)
				0: begin
					send_idle_pct = 28;
					recv_idle_pct = 72;
				end
				1: begin
					send_idle_pct = 72;
					recv_idle_pct = 28;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			plan_st = dec_st;
			words_planned = 0;
			while (words_planned < PHASE_WORDS) begin
				case ($urandom_range(0, 24))
					0: add_word(mk_desc(16'($urandom)));
					1: add_word(mk_push($urandom, $urandom));
					default: add_record();
				endcase
			end
			drain();
		end

		repeat (TAIL_CYCLES) @(negedge clk);
		$display("Took %0d words and checked %0d records (%0d starved)",
			words_taken, records_seen, starved_seen);
		$display("across %0d register writes, idle mixes on both sides and one long hold-off.",
			settings_used);
		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("%0d mismatching records", errors);
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
